### sv/mexp_pkg.sv
// package for the modular exponentiation core
// shared constants and the front-to-back word type; no dependencies
package mexp_pkg;

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [IDX_W-1:0] REG_EXPONENT = 1'b1;

  // job word handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
  } job_t;

endpackage

### sv/mexp_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module mexp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/mexp_front.sv
// front part: takes input words into a short queue toward the back part
// depends on mexp_pkg and mexp_ram
module mexp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [30:0]    value,
  output logic           full,
  input  logic           take,
  output logic           job_vld,
  output mexp_pkg::job_t job
);
  import mexp_pkg::*;

  // 4-deep queue; output word registered via ram read, prefetched into a head reg
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       hv_r, hv_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  logic [VAL_W-1:0] rdata;
  job_t       head_r, head_nxt;
  logic       wr, rd;

  assign full = (cnt_r == 3'd4);
  assign wr   = push && !full;
  // fetch a word when head is free (or freeing) and none in flight
  assign rd   = (cnt_r != 3'd0) && !rd_pend_r && (!hv_r || take);

  mexp_ram #(.WIDTH(VAL_W), .DEPTH(4)) u_q (
    .clk(clk), .we(wr), .waddr(wp_r), .wdata(value), .raddr(rp_r), .rdata(rdata)
  );

  always_comb begin
    wp_nxt = wr ? wp_r + 2'd1 : wp_r;
    rp_nxt = rd ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b0, wr} - {2'b0, rd};
    rd_pend_nxt = rd;
    hv_nxt = hv_r && !take;
    head_nxt = head_r;
    if (rd_pend_r) begin
      hv_nxt = 1'b1;
      head_nxt.value = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; hv_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt; hv_r <= hv_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    head_r <= head_nxt;
  end

  assign job_vld = hv_r;
  assign job     = head_r;
endmodule

### sv/mexp_back.sv
// back part: square and multiply with a bit-serial modular multiplier
// depends on mexp_pkg
module mexp_back #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_vld,
  input  mexp_pkg::job_t      job,
  output logic                take,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic [EXP_BITS-1:0] exponent,
  output logic                res_vld,
  output logic [30:0]         res,
  input  logic                res_pop
);
  import mexp_pkg::*;

  localparam int EB = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int MB = $clog2(MOD_BITS + 1);
  localparam int VB = $clog2(VAL_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_SQ = 3'd2, S_MUL = 3'd3,
                         S_MM = 3'd4, S_OUT = 3'd5;

  logic [2:0]          st_r, st_nxt, ret_r, ret_nxt;
  logic [MOD_BITS-1:0] base_r, base_nxt, acc_r, acc_nxt;
  logic [MOD_BITS-1:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [MOD_BITS:0]   p_r, p_nxt;       // running partial, < modulus
  logic [VAL_W-1:0]    v_r, v_nxt;
  logic [VB-1:0]       vi_r, vi_nxt;
  logic [MB-1:0]       mi_r, mi_nxt;
  logic [EB-1:0]       bi_r, bi_nxt;
  logic [30:0]         res_r, res_nxt;
  logic [MOD_BITS+1:0] dbl, add, t;
  logic [MOD_BITS+1:0] sh, shr;

  // one step of horner: p = 2p (+b) mod m, two conditional subtracts
  always_comb begin
    dbl = {1'b0, p_r} << 1;
    if (dbl >= {2'b0, modulus}) dbl = dbl - {2'b0, modulus};
    add = dbl + (ma_r[mi_r[MB-1:0]] ? {2'b0, mb_r} : '0);
    t   = (add >= {2'b0, modulus}) ? add - {2'b0, modulus} : add;
  end

  // one step of the input reduction: p = 2p + next value bit, mod m
  assign sh  = {p_r, v_r[vi_r[$clog2(VAL_W)-1:0]]};
  assign shr = (sh >= {2'b0, modulus}) ? sh - {2'b0, modulus} : sh;

  assign take = (st_r == S_IDLE) && job_vld && !res_vld;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; base_nxt = base_r; acc_nxt = acc_r;
    ma_nxt = ma_r; mb_nxt = mb_r; p_nxt = p_r; v_nxt = v_r; vi_nxt = vi_r;
    mi_nxt = mi_r; bi_nxt = bi_r; res_nxt = res_r;
    unique case (st_r)
      S_IDLE: begin
        if (take) begin
          if (exponent == '0) begin
            res_nxt = 31'd1; st_nxt = S_OUT;
          end else if (modulus == '0) begin
            res_nxt = '0; st_nxt = S_OUT;
          end else begin
            v_nxt = job.value; vi_nxt = VB'(VAL_W - 1); p_nxt = '0; st_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        // bit-serial reduction of the input value
        p_nxt = shr[MOD_BITS:0];
        if (vi_r == '0) begin
          base_nxt = shr[MOD_BITS-1:0];
          acc_nxt  = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
          bi_nxt   = EB'(EXP_BITS - 1);
          st_nxt   = S_SQ;
        end else begin
          vi_nxt = vi_r - VB'(1);
        end
      end
      S_SQ: begin
        ma_nxt = acc_r; mb_nxt = acc_r; p_nxt = '0; mi_nxt = MB'(MOD_BITS - 1);
        ret_nxt = S_MUL; st_nxt = S_MM;
      end
      S_MUL: begin
        if (exponent[bi_r]) begin
          ma_nxt = acc_r; mb_nxt = base_r; p_nxt = '0; mi_nxt = MB'(MOD_BITS - 1);
          ret_nxt = S_IDLE; st_nxt = S_MM;   // ret idle marks next-bit step
        end else if (bi_r == '0) begin
          res_nxt = 31'(acc_r); st_nxt = S_OUT;
        end else begin
          bi_nxt = bi_r - EB'(1); st_nxt = S_SQ;
        end
      end
      S_MM: begin
        p_nxt = t[MOD_BITS:0];
        if (mi_r == '0) begin
          acc_nxt = MOD_BITS'(t);
          if (ret_r == S_MUL) begin
            st_nxt = S_MUL;
          end else if (bi_r == '0) begin
            res_nxt = 31'(t); st_nxt = S_OUT;
          end else begin
            bi_nxt = bi_r - EB'(1); st_nxt = S_SQ;
          end
        end else begin
          mi_nxt = mi_r - MB'(1);
        end
      end
      S_OUT: begin
        if (res_pop) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ret_r <= ret_nxt; base_r <= base_nxt; acc_r <= acc_nxt; ma_r <= ma_nxt;
    mb_r <= mb_nxt; p_r <= p_nxt; v_r <= v_nxt; vi_r <= vi_nxt; mi_r <= mi_nxt;
    bi_r <= bi_nxt; res_r <= res_nxt;
  end

  assign res_vld = (st_r == S_OUT);
  assign res     = res_r;
endmodule

### sv/modular_exponentiation_core.sv
// top level of the modular exponentiation core
// depends on mexp_pkg, mexp_front, mexp_back
// Computes value^exponent mod modulus by left-to-right square and multiply.
// Input words enter a 4-deep queue (front) and are served one at a time by
// the back part, whose bit-serial modular multiplier is shared by the square
// and the multiply. An item first has its input value reduced bit by bit,
// then gets, per exponent bit, a square and the bit test, plus a multiply
// when the bit is set; every exponent bit is scanned. Exponent zero gives 1
// at once. The result is held until popped; the next word waits in the
// queue meanwhile. Configure only while idle.
module modular_exponentiation_core #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [30:0] in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [30:0] out_power,
  input  logic        cfg_we,
  input  logic [mexp_pkg::IDX_W-1:0] cfg_idx,
  input  logic [31:0] cfg_wdata
);
  import mexp_pkg::*;

  logic [MOD_BITS-1:0] mod_r;
  logic [EXP_BITS-1:0] exp_r;
  logic job_vld, take, res_vld;
  job_t job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_BITS'(1);
      exp_r <= EXP_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODULUS:  mod_r <= cfg_wdata[MOD_BITS-1:0];
        REG_EXPONENT: exp_r <= cfg_wdata[EXP_BITS-1:0];
        default: ;
      endcase
    end
  end

  mexp_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .value(in_value), .full(in_full),
    .take(take), .job_vld(job_vld), .job(job)
  );

  mexp_back #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_vld(job_vld), .job(job), .take(take),
    .modulus(mod_r), .exponent(exp_r), .res_vld(res_vld), .res(out_power),
    .res_pop(out_pop)
  );

  assign out_empty = !res_vld;
endmodule

### sv/mexp_checker.sv
// port-level checker for the modular exponentiation core
// depends on modular_exponentiation_core (bound to it)
module mexp_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [30:0] out_power
);
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown after reset");
  a_rst_notfull: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("full after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_power)))
    else $error("waiting word changed");
  a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop) |=> out_empty)
    else $error("results back to back");
endmodule

bind modular_exponentiation_core mexp_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_power(out_power)
);
